// File: design/calu_pkg.sv
// ----------------------------------------------------------------------------
// calu_pkg - shared types for the 8-bit ALU with flags
// Operation codes, the flag nibble layout and the request bundle that moves
// from the input stage to the execute logic.
// ----------------------------------------------------------------------------
package calu_pkg;

  // Operation codes as carried on the input channel's tuser.
  typedef enum logic [4:0] {
    OP_ADD    = 5'd0,
    OP_ADC    = 5'd1,
    OP_SUB    = 5'd2,
    OP_SBC    = 5'd3,
    OP_AND    = 5'd4,
    OP_OR     = 5'd5,
    OP_XOR    = 5'd6,
    OP_CP     = 5'd7,
    OP_INC    = 5'd8,
    OP_DEC    = 5'd9,
    OP_RLC    = 5'd10,
    OP_RL     = 5'd11,
    OP_RRC    = 5'd12,
    OP_RR     = 5'd13,
    OP_SLA    = 5'd14,
    OP_SRA    = 5'd15,
    OP_SRL    = 5'd16,
    OP_SWAP   = 5'd17,
    OP_BIT    = 5'd18,
    OP_SET    = 5'd19,
    OP_RES    = 5'd20,
    OP_CPL    = 5'd21,
    OP_CCF    = 5'd22,
    OP_SCF    = 5'd23,
    OP_RLCA   = 5'd24,
    OP_RLA    = 5'd25,
    OP_RRCA   = 5'd26,
    OP_RRA    = 5'd27,
    OP_ADD16  = 5'd28,
    OP_ADD16S = 5'd29,
    OP_LDA    = 5'd30,
    OP_LDF    = 5'd31
  } op_t;

  // Flag nibble, Z in the top bit down to C in the bottom bit.
  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } flags_t;

  // One operation request as held in the input stage.
  typedef struct packed {
    op_t         op;
    logic [7:0]  operand;
    logic [15:0] wide_base;
    logic [15:0] wide_addend;
    logic [2:0]  bit_index;
  } req_t;

endpackage

// File: design/calu_exec.sv
// ----------------------------------------------------------------------------
// calu_exec - execute logic of the 8-bit ALU
// Computes the result word, the next accumulator and the next flags for one
// request from the current accumulator and flags.
// ----------------------------------------------------------------------------
module calu_exec (
  input  calu_pkg::req_t   req,
  input  logic [7:0]       acc,
  input  calu_pkg::flags_t flags,
  output logic [15:0]      result,
  output logic [7:0]       acc_nxt,
  output calu_pkg::flags_t flags_nxt
);

  logic        add_t;
  logic        sub_t;
  logic [8:0]  sum9;
  logic [4:0]  sum5;
  logic [8:0]  dif9;
  logic [4:0]  dif5;
  logic [7:0]  logic_res;
  logic        acc_rot;
  logic [7:0]  src;
  logic [7:0]  rot;
  logic        rot_c;
  logic [7:0]  mask;
  logic [16:0] sum17;
  logic [12:0] sum13;
  logic [8:0]  off9;
  logic [4:0]  off5;
  logic [15:0] sext;
  logic [7:0]  inc8;
  logic [7:0]  dec8;
  logic        acc_res;

  // Shared arithmetic; the borrow of a subtract shows as the top bit.
  always_comb begin
    add_t = (req.op == calu_pkg::OP_ADC) && flags.c;
    sub_t = (req.op == calu_pkg::OP_SBC) && flags.c;
    sum9  = {1'b0, acc} + {1'b0, req.operand} + {8'h00, add_t};
    sum5  = {1'b0, acc[3:0]} + {1'b0, req.operand[3:0]} + {4'h0, add_t};
    dif9  = {1'b0, acc} - {1'b0, req.operand} - {8'h00, sub_t};
    dif5  = {1'b0, acc[3:0]} - {1'b0, req.operand[3:0]} - {4'h0, sub_t};
    sum17 = {1'b0, req.wide_base} + {1'b0, req.wide_addend};
    sum13 = {1'b0, req.wide_base[11:0]} + {1'b0, req.wide_addend[11:0]};
    off9  = {1'b0, req.wide_base[7:0]} + {1'b0, req.operand};
    off5  = {1'b0, req.wide_base[3:0]} + {1'b0, req.operand[3:0]};
    sext  = req.wide_base + {{8{req.operand[7]}}, req.operand};
    inc8  = req.operand + 8'd1;
    dec8  = req.operand - 8'd1;
    mask  = 8'b1 << req.bit_index;
  end

  // Rotate and shift unit, shared by the register and accumulator forms.
  always_comb begin
    acc_rot = (req.op == calu_pkg::OP_RLCA) || (req.op == calu_pkg::OP_RLA) ||
              (req.op == calu_pkg::OP_RRCA) || (req.op == calu_pkg::OP_RRA);
    src = acc_rot ? acc : req.operand;
    unique case (req.op)
      calu_pkg::OP_RLC, calu_pkg::OP_RLCA: begin
        rot = {src[6:0], src[7]};   rot_c = src[7];
      end
      calu_pkg::OP_RL, calu_pkg::OP_RLA: begin
        rot = {src[6:0], flags.c};  rot_c = src[7];
      end
      calu_pkg::OP_RRC, calu_pkg::OP_RRCA: begin
        rot = {src[0], src[7:1]};   rot_c = src[0];
      end
      calu_pkg::OP_RR, calu_pkg::OP_RRA: begin
        rot = {flags.c, src[7:1]};  rot_c = src[0];
      end
      calu_pkg::OP_SLA: begin
        rot = {src[6:0], 1'b0};     rot_c = src[7];
      end
      calu_pkg::OP_SRA: begin
        rot = {src[7], src[7:1]};   rot_c = src[0];
      end
      calu_pkg::OP_SRL: begin
        rot = {1'b0, src[7:1]};     rot_c = src[0];
      end
      default: begin
        rot = src;                  rot_c = 1'b0;
      end
    endcase
  end

  always_comb begin
    acc_nxt   = acc;
    flags_nxt = flags;
    result    = 16'h0000;
    acc_res   = 1'b0;
    logic_res = 8'h00;
    unique case (req.op)
      calu_pkg::OP_ADD, calu_pkg::OP_ADC: begin
        acc_nxt     = sum9[7:0];
        flags_nxt.z = (sum9[7:0] == 8'h00);
        flags_nxt.n = 1'b0;
        flags_nxt.h = sum5[4];
        flags_nxt.c = sum9[8];
        acc_res     = 1'b1;
      end
      calu_pkg::OP_SUB, calu_pkg::OP_SBC, calu_pkg::OP_CP: begin
        // Compare sets the flags of a subtract but leaves A alone.
        if (req.op != calu_pkg::OP_CP) begin
          acc_nxt = dif9[7:0];
        end
        flags_nxt.z = (dif9[7:0] == 8'h00);
        flags_nxt.n = 1'b1;
        flags_nxt.h = dif5[4];
        flags_nxt.c = dif9[8];
        acc_res     = 1'b1;
      end
      calu_pkg::OP_AND, calu_pkg::OP_OR, calu_pkg::OP_XOR: begin
        if (req.op == calu_pkg::OP_AND) begin
          logic_res = acc & req.operand;
        end else if (req.op == calu_pkg::OP_OR) begin
          logic_res = acc | req.operand;
        end else begin
          logic_res = acc ^ req.operand;
        end
        acc_nxt     = logic_res;
        flags_nxt.z = (logic_res == 8'h00);
        flags_nxt.n = 1'b0;
        flags_nxt.h = (req.op == calu_pkg::OP_AND);
        flags_nxt.c = 1'b0;
        acc_res     = 1'b1;
      end
      calu_pkg::OP_INC: begin
        result      = {8'h00, inc8};
        flags_nxt.z = (inc8 == 8'h00);
        flags_nxt.n = 1'b0;
        flags_nxt.h = (inc8[3:0] == 4'h0);
      end
      calu_pkg::OP_DEC: begin
        result      = {8'h00, dec8};
        flags_nxt.z = (dec8 == 8'h00);
        flags_nxt.n = 1'b1;
        flags_nxt.h = (dec8[3:0] == 4'hF);
      end
      calu_pkg::OP_RLC, calu_pkg::OP_RL, calu_pkg::OP_RRC, calu_pkg::OP_RR,
      calu_pkg::OP_SLA, calu_pkg::OP_SRA, calu_pkg::OP_SRL: begin
        result      = {8'h00, rot};
        flags_nxt.z = (rot == 8'h00);
        flags_nxt.n = 1'b0;
        flags_nxt.h = 1'b0;
        flags_nxt.c = rot_c;
      end
      calu_pkg::OP_RLCA, calu_pkg::OP_RLA, calu_pkg::OP_RRCA, calu_pkg::OP_RRA: begin
        // Accumulator rotates always clear Z.
        acc_nxt     = rot;
        flags_nxt.z = 1'b0;
        flags_nxt.n = 1'b0;
        flags_nxt.h = 1'b0;
        flags_nxt.c = rot_c;
        acc_res     = 1'b1;
      end
      calu_pkg::OP_SWAP: begin
        result      = {8'h00, req.operand[3:0], req.operand[7:4]};
        flags_nxt   = '0;
        flags_nxt.z = (req.operand == 8'h00);
      end
      calu_pkg::OP_BIT: begin
        result      = {8'h00, req.operand};
        flags_nxt.z = ((req.operand & mask) == 8'h00);
        flags_nxt.n = 1'b0;
        flags_nxt.h = 1'b1;
      end
      calu_pkg::OP_SET: begin
        result = {8'h00, req.operand | mask};
      end
      calu_pkg::OP_RES: begin
        result = {8'h00, req.operand & ~mask};
      end
      calu_pkg::OP_CPL: begin
        acc_nxt     = ~acc;
        flags_nxt.n = 1'b1;
        flags_nxt.h = 1'b1;
        acc_res     = 1'b1;
      end
      calu_pkg::OP_CCF, calu_pkg::OP_SCF: begin
        flags_nxt.n = 1'b0;
        flags_nxt.h = 1'b0;
        flags_nxt.c = (req.op == calu_pkg::OP_SCF) ? 1'b1 : ~flags.c;
        acc_res     = 1'b1;
      end
      calu_pkg::OP_ADD16: begin
        result      = sum17[15:0];
        flags_nxt.n = 1'b0;
        flags_nxt.h = sum13[12];
        flags_nxt.c = sum17[16];
      end
      calu_pkg::OP_ADD16S: begin
        // Flags come from the unsigned add of the offset byte to the low byte.
        result      = sext;
        flags_nxt   = '0;
        flags_nxt.h = off5[4];
        flags_nxt.c = off9[8];
      end
      calu_pkg::OP_LDA: begin
        acc_nxt = req.operand;
        acc_res = 1'b1;
      end
      calu_pkg::OP_LDF: begin
        flags_nxt = calu_pkg::flags_t'(req.operand[7:4]);
        acc_res   = 1'b1;
      end
    endcase
    if (acc_res) begin
      result = {8'h00, acc_nxt};
    end
  end

endmodule

// File: design/cpu_alu_with_flags.sv
// ----------------------------------------------------------------------------
// cpu_alu_with_flags - 8-bit CPU ALU holding the accumulator and Z/N/H/C flags
//
// Each input beat carries one operation: the opcode on in_tuser and the
// operands on in_tdata. The block executes operations strictly in order
// against its own accumulator and flag registers and returns one output beat
// per input beat, carrying the 16-bit result word, the new accumulator and
// the four flags.
//
// A beat accepted by the block is registered in the input stage, executed by
// the combinational execute logic and registered in the output register,
// which drives out_tvalid. The block takes one beat per clock while the output
// is not stalled; the accumulator and flags feed back through the execute logic,
// so dependent operations follow each other with no bubble.
//
// Reset (rst_n low at a clock edge) empties both stages and clears the
// accumulator and all flags. When the receiver holds out_tready low the
// output register keeps its beat, one more beat may wait in the input stage,
// and in_tready falls only when both are full. State updates only when a beat
// moves from the input stage to the output register, so stalls never change
// the results.
// ----------------------------------------------------------------------------
module cpu_alu_with_flags (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] operand, [23:8] wide_base, [39:24] wide_addend, [42:40] bit_index,
  // [47:43] zero
  input  logic [47:0] in_tdata,
  // [4:0] req_type
  input  logic [4:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [15:0] result, [23:16] acc_out, [24] flag_zero, [25] flag_subtract,
  // [26] flag_half_carry, [27] flag_carry, [31:28] zero
  output logic [31:0] out_tdata
);

  logic             in_fire;
  logic             adv;

  // Input stage.
  logic             s1_valid_r;
  logic             s1_valid_nxt;
  calu_pkg::req_t   s1_req_r;
  calu_pkg::req_t   s1_req_nxt;

  // Architectural state.
  logic [7:0]       acc_r;
  calu_pkg::flags_t flags_r;

  // Execute results.
  logic [15:0]      exe_result;
  logic [7:0]       acc_nxt;
  calu_pkg::flags_t flags_nxt;

  // Output register.
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic [15:0]      out_result_r;
  logic [7:0]       out_acc_r;
  calu_pkg::flags_t out_flags_r;

  // The input stage moves on when the output register is empty or draining.
  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    s1_req_nxt.op          = calu_pkg::op_t'(in_tuser);
    s1_req_nxt.operand     = in_tdata[7:0];
    s1_req_nxt.wide_base   = in_tdata[23:8];
    s1_req_nxt.wide_addend = in_tdata[39:24];
    s1_req_nxt.bit_index   = in_tdata[42:40];
  end

  always_comb begin
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  calu_exec u_exec (
    .req       (s1_req_r),
    .acc       (acc_r),
    .flags     (flags_r),
    .result    (exe_result),
    .acc_nxt   (acc_nxt),
    .flags_nxt (flags_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= 8'h00;
      flags_r     <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (adv) begin
        acc_r   <= acc_nxt;
        flags_r <= flags_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_req_r <= s1_req_nxt;
    end
    if (adv) begin
      out_result_r <= exe_result;
      out_acc_r    <= acc_nxt;
      out_flags_r  <= flags_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'h0, out_flags_r.c, out_flags_r.h, out_flags_r.n,
                       out_flags_r.z, out_acc_r, out_result_r};

  // The beat on the output always reports the current architectural state.
  a_out_acc_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_acc_r == acc_r))
    else $error("output accumulator differs from accumulator register");

  a_out_flags_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_flags_r == flags_r))
    else $error("output flags differ from flag register");

  // A flag load puts the operand's upper nibble straight into the flags.
  a_load_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && (s1_req_r.op == calu_pkg::OP_LDF)) |=>
      (flags_r == calu_pkg::flags_t'($past(s1_req_r.operand[7:4]))))
    else $error("flag load did not take the operand nibble");

  // Input backpressure only when both stages are full and the output stalls.
  a_ready_low_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && out_valid_r && !out_tready))
    else $error("input stalled without a full pipeline");

  // A waiting input-stage beat is never dropped during an output stall.
  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !adv) |=> s1_valid_r)
    else $error("input stage lost a beat");

endmodule
